[rtl/core/bkrd_pkg.sv]
package bkrd_pkg;

  localparam int LEN_W = 7;
  localparam int MOD_W = 8;
  localparam int KEY_W = 8;
  localparam int SK_W  = 4;
  localparam int SK_IDX_W = $clog2(SK_W);

  localparam logic [LEN_W-1:0] MIN_REPORT_LEN     = 7'd8;
  localparam logic [KEY_W-1:0] LAST_RESERVED_CODE = 8'h03;
  localparam logic [KEY_W-1:0] SOFTKEY_FIRST      = 8'h1E;
  localparam logic [KEY_W-1:0] SOFTKEY_COUNT      = 8'd4;

  // Output word width: key, modifier and flags, padded to whole bytes.
  localparam int OUT_BITS = KEY_W + MOD_W + SK_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             is_press;
    logic [MOD_W-1:0] modifier;
    logic [SK_W-1:0]  flags;
    logic             last;
  } event_t;

endpackage

[rtl/core/bkrd_front.sv]
module bkrd_front #(
  parameter int KEY_SLOTS = 6,
  localparam int EntryW = bkrd_pkg::MOD_W + 2 * KEY_SLOTS * bkrd_pkg::KEY_W + 2 * KEY_SLOTS
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_ready_o,
  input  logic [bkrd_pkg::LEN_W-1:0]                 len_i,
  input  logic [bkrd_pkg::MOD_W-1:0]                 mod_i,
  input  logic [KEY_SLOTS-1:0][bkrd_pkg::KEY_W-1:0]  keys_i,
  input  logic                                       full_i,
  output logic                                       push_o,
  output logic [EntryW-1:0]                          entry_o
);
  import bkrd_pkg::*;

  logic [KEY_SLOTS-1:0][KEY_W-1:0] prev_keys_q, prev_keys_d;
  logic [KEY_SLOTS-1:0]            rel_mask, prs_mask;
  logic                            accept, long_report;

  assign in_ready_o  = !full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign long_report = (len_i >= MIN_REPORT_LEN);

  // Release: old real key gone from the new report. Press: new real key not held before.
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      logic old_seen, new_seen;
      old_seen = 1'b0;
      new_seen = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (keys_i[j] == prev_keys_q[i]) old_seen = 1'b1;
        if (prev_keys_q[j] == keys_i[i]) new_seen = 1'b1;
      end
      rel_mask[i] = (prev_keys_q[i] > LAST_RESERVED_CODE) && !old_seen;
      prs_mask[i] = (keys_i[i] > LAST_RESERVED_CODE) && !new_seen;
    end
  end

  assign prev_keys_d = (accept && long_report) ? keys_i : prev_keys_q;

  // Drop reports that cause no events; the key history still advances.
  assign push_o  = accept && long_report && (|{rel_mask, prs_mask});
  assign entry_o = {mod_i, keys_i, prev_keys_q, rel_mask, prs_mask};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= '0;
    end else begin
      prev_keys_q <= prev_keys_d;
    end
  end

endmodule

[rtl/core/bkrd_queue.sv]
module bkrd_queue #(
  parameter int WIDTH = 116,
  parameter int DEPTH = 2,
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [DEPTH-1:0][WIDTH-1:0] slots_q;
  logic [PtrW-1:0]             wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slots_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
    if (do_pop)  rptr_d = (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= wdata_i;
  end

endmodule

[rtl/core/bkrd_back.sv]
module bkrd_back #(
  parameter int KEY_SLOTS = 6,
  localparam int EntryW = bkrd_pkg::MOD_W + 2 * KEY_SLOTS * bkrd_pkg::KEY_W + 2 * KEY_SLOTS,
  localparam int SlotW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  input  logic [EntryW-1:0] entry_i,
  output logic              evt_valid_o,
  input  logic              evt_ready_i,
  output bkrd_pkg::event_t  evt_o
);
  import bkrd_pkg::*;

  logic [MOD_W-1:0]                e_mod;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] e_now, e_prev;
  logic [KEY_SLOTS-1:0]            e_rel, e_prs;

  logic [MOD_W-1:0]                mod_q, mod_d;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] now_q, now_d, prev_q, prev_d;
  logic [KEY_SLOTS-1:0]            rel_q, rel_d, prs_q, prs_d;
  logic [KEY_SLOTS-1:0]            rel_left, prs_left;
  logic [SK_W-1:0]                 flags_q, flags_d, flags_nxt;
  logic                            out_valid_q, out_valid_d;
  event_t                          out_q, out_d;

  logic             pending, fire, sel_press, sk_hit;
  logic [SlotW-1:0] sel_slot;
  logic [KEY_W-1:0] sel_key, sk_off;

  assign {e_mod, e_now, e_prev, e_rel, e_prs} = entry_i;

  assign pending = |{rel_q, prs_q};
  assign q_pop_o = !pending && q_valid_i;
  assign fire    = pending && (!out_valid_q || evt_ready_i);

  // Lowest pending candidate wins; within a slot the release goes first.
  always_comb begin
    sel_slot  = '0;
    sel_press = 1'b0;
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (prs_q[i]) begin
        sel_slot  = SlotW'(i);
        sel_press = 1'b1;
      end
      if (rel_q[i]) begin
        sel_slot  = SlotW'(i);
        sel_press = 1'b0;
      end
    end
  end

  assign sel_key = sel_press ? now_q[sel_slot] : prev_q[sel_slot];
  assign sk_off  = sel_key - SOFTKEY_FIRST;
  assign sk_hit  = (sel_key >= SOFTKEY_FIRST) && (sk_off < SOFTKEY_COUNT);

  always_comb begin
    flags_nxt = flags_q;
    if (sk_hit) flags_nxt[sk_off[SK_IDX_W-1:0]] = sel_press;
  end

  always_comb begin
    rel_left = rel_q;
    prs_left = prs_q;
    if (sel_press) prs_left[sel_slot] = 1'b0;
    else           rel_left[sel_slot] = 1'b0;
  end

  always_comb begin
    mod_d       = mod_q;
    now_d       = now_q;
    prev_d      = prev_q;
    rel_d       = rel_q;
    prs_d       = prs_q;
    flags_d     = flags_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (evt_ready_i) out_valid_d = 1'b0;
    if (q_pop_o) begin
      mod_d  = e_mod;
      now_d  = e_now;
      prev_d = e_prev;
      rel_d  = e_rel;
      prs_d  = e_prs;
    end else if (fire) begin
      rel_d          = rel_left;
      prs_d          = prs_left;
      flags_d        = flags_nxt;
      out_valid_d    = 1'b1;
      out_d.key      = sel_key;
      out_d.is_press = sel_press;
      out_d.modifier = sel_press ? mod_q : '0;
      out_d.flags    = flags_nxt;
      out_d.last     = !(|{rel_left, prs_left});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q       <= '0;
      prs_q       <= '0;
      flags_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rel_q       <= rel_d;
      prs_q       <= prs_d;
      flags_q     <= flags_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mod_q  <= mod_d;
    now_q  <= now_d;
    prev_q <= prev_d;
    out_q  <= out_d;
  end

  assign evt_valid_o = out_valid_q;
  assign evt_o       = out_q;

endmodule

[rtl/core/boot_keyboard_report_differ.sv]
// Channel   Dir  Words                Fields (tdata / tuser / tlast)
// s_axis    in   one report           length, modifier, key slots / - / -
// m_axis    out  one key event        key, modifier, softkey flags / is_press / last
//
// Reports are accepted one per cycle while the two-entry queue has room; short
// reports and reports without key changes are absorbed at once.
// The event unit loads a report only when no events of the previous report are pending, then
// emits one event per cycle while m_axis is not stalled; a report yields at most 2*KEY_SLOTS events.
// m_axis stalls hold the event register and back up into the queue.
// Reset clears key history, softkey flags and all valid state.
module boot_keyboard_report_differ #(
  parameter int KEY_SLOTS = 6,
  localparam int InBits = bkrd_pkg::LEN_W + bkrd_pkg::MOD_W + KEY_SLOTS * bkrd_pkg::KEY_W,
  localparam int InW = ((InBits + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // report_length, modifier_bits, key_slot_0 .. key_slot_N-1, zero pad
  input  logic [InW-1:0]             s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // event_key, event_modifier, softkey_flags, zero pad
  output logic [bkrd_pkg::OUT_W-1:0] m_axis_tdata,
  // is_press
  output logic [0:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);
  import bkrd_pkg::*;

  localparam int EntryW = MOD_W + 2 * KEY_SLOTS * KEY_W + 2 * KEY_SLOTS;

  logic [LEN_W-1:0]                in_len;
  logic [MOD_W-1:0]                in_mod;
  logic [KEY_SLOTS-1:0][KEY_W-1:0] in_keys;
  logic                            q_push, q_full, q_pop, q_valid;
  logic [EntryW-1:0]               q_wdata, q_rdata;
  event_t                          evt;

  assign in_len  = s_axis_tdata[LEN_W-1:0];
  assign in_mod  = s_axis_tdata[LEN_W +: MOD_W];
  assign in_keys = s_axis_tdata[LEN_W + MOD_W +: KEY_SLOTS * KEY_W];

  bkrd_front #(.KEY_SLOTS(KEY_SLOTS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .len_i      (in_len),
    .mod_i      (in_mod),
    .keys_i     (in_keys),
    .full_i     (q_full),
    .push_o     (q_push),
    .entry_o    (q_wdata)
  );

  bkrd_queue #(.WIDTH(EntryW), .DEPTH(2)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rdata_o (q_rdata)
  );

  bkrd_back #(.KEY_SLOTS(KEY_SLOTS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .entry_i     (q_rdata),
    .evt_valid_o (m_axis_tvalid),
    .evt_ready_i (m_axis_tready),
    .evt_o       (evt)
  );

  assign m_axis_tdata = OUT_W'({evt.flags, evt.modifier, evt.key});
  assign m_axis_tuser = evt.is_press;
  assign m_axis_tlast = evt.last;

endmodule

[rtl/core/bkrd_checker.sv]
module bkrd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [bkrd_pkg::OUT_W-1:0] m_axis_tdata,
  input logic [0:0]                 m_axis_tuser,
  input logic                       m_axis_tlast
);
  import bkrd_pkg::*;

  logic [KEY_W-1:0]    ev_key;
  logic [MOD_W-1:0]    ev_mod;
  logic [SK_W-1:0]     ev_flags;
  logic [SK_IDX_W-1:0] sk_idx;
  logic                sk_key, sk_bit;

  assign ev_key   = m_axis_tdata[KEY_W-1:0];
  assign ev_mod   = m_axis_tdata[KEY_W +: MOD_W];
  assign ev_flags = m_axis_tdata[KEY_W + MOD_W +: SK_W];
  assign sk_idx   = SK_IDX_W'(ev_key - SOFTKEY_FIRST);
  assign sk_key   = (ev_key >= SOFTKEY_FIRST) && (ev_key < SOFTKEY_FIRST + SOFTKEY_COUNT);
  assign sk_bit   = ev_flags[sk_idx];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("event changed while stalled");

  a_real_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ev_key > LAST_RESERVED_CODE)
    else $error("event for reserved code");

  a_release_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> ev_mod == '0)
    else $error("release carries a modifier");

  a_softkey_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && sk_key |-> sk_bit == m_axis_tuser[0])
    else $error("softkey flag does not follow event");

endmodule

bind boot_keyboard_report_differ bkrd_checker u_bkrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[test/tb_boot_keyboard_report_differ.sv]
module tb_boot_keyboard_report_differ;
  import bkrd_pkg::*;

  localparam int SLOTS = 6;
  localparam int IN_W = ((LEN_W + MOD_W + SLOTS * KEY_W + 7) / 8) * 8;
  localparam int IN_PAD = IN_W - LEN_W - MOD_W - SLOTS * KEY_W;
  localparam int RANDOM_REPORTS = 190;
  localparam int CALM_REPORTS = 30;
  localparam int TAIL_CYCLES = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 40;

  // One report word plus, for directed rows, the event typed in by hand.
  typedef struct packed {
    logic [LEN_W-1:0]            len;
    logic [MOD_W-1:0]            mod;
    logic [SLOTS-1:0][KEY_W-1:0] keys;
    logic                        typed;
    logic                        typed_n;
    event_t                      ev;
  } report_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0] m_axis_tuser;
  logic m_axis_tlast;

  logic [KEY_W-1:0] held_keys [SLOTS] = '{default: '0};
  logic [SK_W-1:0] soft_flags = '0;
  logic [SLOTS-1:0][KEY_W-1:0] last_sent = '0;

  report_row_t reports_in_flight[$];
  report_row_t stim_tab[$];
  event_t events_due[$];
  int unsigned reports_taken = 0;
  int unsigned events_seen = 0;
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;
  int unsigned sink_left = 0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  boot_keyboard_report_differ #(
    .KEY_SLOTS(SLOTS)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("%0t mismatch in %s on event %0d: got %0h, expected %0h",
               $realtime, what, events_seen, got, want);
  endtask

  // Apply one key change to the softkey flags and build its event word.
  function automatic event_t apply_key(input logic [KEY_W-1:0] code, input logic press,
                                       input logic [MOD_W-1:0] mod);
    event_t ev;
    logic [KEY_W-1:0] idx;
    idx = code - SOFTKEY_FIRST;
    if (code >= SOFTKEY_FIRST && idx < SOFTKEY_COUNT) soft_flags[idx[SK_IDX_W-1:0]] = press;
    ev = '{key: code, is_press: press, modifier: press ? mod : 8'h00, flags: soft_flags,
           last: 1'b0};
    return ev;
  endfunction

  // Diff a report against held keys; queue its events, or a typed row's own event.
  function automatic void take_report(input report_row_t r);
    logic [KEY_W-1:0] now_keys [SLOTS];
    event_t evs[$];
    event_t tail_ev;
    logic [KEY_W-1:0] old_k;
    logic [KEY_W-1:0] cur_k;
    bit in_now;
    bit in_old;
    if (r.len >= MIN_REPORT_LEN) begin
      for (int i = 0; i < SLOTS; i++) now_keys[i] = r.keys[i];
      for (int i = 0; i < SLOTS; i++) begin
        old_k = held_keys[i];
        cur_k = now_keys[i];
        in_now = 1'b0;
        in_old = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
          in_now |= (now_keys[j] == old_k);
          in_old |= (held_keys[j] == cur_k);
        end
        if (old_k > LAST_RESERVED_CODE && !in_now) evs.push_back(apply_key(old_k, 1'b0, '0));
        if (cur_k > LAST_RESERVED_CODE && !in_old) evs.push_back(apply_key(cur_k, 1'b1, r.mod));
      end
      held_keys = now_keys;
      if (evs.size() != 0) begin
        tail_ev = evs.pop_back();
        tail_ev.last = 1'b1;
        evs.push_back(tail_ev);
      end
    end
    if (r.typed) begin
      if (r.typed_n) events_due.push_back(r.ev);
    end else begin
      foreach (evs[k]) events_due.push_back(evs[k]);
    end
  endfunction

  always @(posedge clk_i) begin
    event_t got;
    event_t want;
    bit moved;
    moved = 1'b0;
    if (s_axis_tvalid && s_axis_tready) begin
      moved = 1'b1;
      reports_taken++;
      take_report(reports_in_flight.pop_front());
    end
    if (m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      got.key      = m_axis_tdata[KEY_W-1:0];
      got.modifier = m_axis_tdata[KEY_W +: MOD_W];
      got.flags    = m_axis_tdata[KEY_W + MOD_W +: SK_W];
      got.is_press = m_axis_tuser[0];
      got.last     = m_axis_tlast;
      if (events_due.size() == 0) begin
        report_mismatch("unexpected event key", got.key, 0);
      end else begin
        want = events_due.pop_front();
        if (got.key != want.key) report_mismatch("key", got.key, want.key);
        if (got.is_press != want.is_press) report_mismatch("press", got.is_press, want.is_press);
        if (got.modifier != want.modifier) report_mismatch("modifier", got.modifier, want.modifier);
        if (got.flags != want.flags) report_mismatch("softkey flags", got.flags, want.flags);
        if (got.last != want.last) report_mismatch("last", got.last, want.last);
      end
      events_seen++;
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  // Sink side: stall bursts and ready runs of random length, steady ready when calm.
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (sink_left != 0) begin
      sink_left <= sink_left - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      sink_left <= $urandom_range(0, 17);
    end else begin
      m_axis_tready <= 1'b1;
      sink_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(0, 20);
    end
  end

  // Called on a falling edge; returns on the falling edge after the word is taken.
  task automatic send_report(input report_row_t r);
    int unsigned target;
    target = reports_taken + 1;
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    reports_in_flight.push_back(r);
    s_axis_tdata <= {{IN_PAD{1'b0}}, r.keys, r.mod, r.len};
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (reports_taken != target);
    if (r.len >= MIN_REPORT_LEN) last_sent = r.keys;
  endtask

  function automatic void add_row(input logic [LEN_W-1:0] len, input logic [MOD_W-1:0] mod,
                                  input logic [KEY_W-1:0] k0, input logic [KEY_W-1:0] k1,
                                  input logic [KEY_W-1:0] k2, input logic [KEY_W-1:0] k3,
                                  input logic [KEY_W-1:0] k4, input logic [KEY_W-1:0] k5,
                                  input logic typed, input logic typed_n, input event_t ev);
    report_row_t r;
    r.len = len;
    r.mod = mod;
    r.keys = {k5, k4, k3, k2, k1, k0};
    r.typed = typed;
    r.typed_n = typed_n;
    r.ev = ev;
    stim_tab.push_back(r);
  endfunction

  initial begin
    report_row_t r;
    int unsigned long_reports;
    int unsigned pick;
    event_t none;
    none = '0;

    // Typed rows start from reset: nothing held, all softkeys clear.
    add_row(7'd8, 8'hFF, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
            '{key: 8'h1E, is_press: 1'b1, modifier: 8'hFF, flags: 4'h1, last: 1'b1});
    // short reports are dropped
    add_row(7'd7, 8'h12, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 1'b1, 1'b0, none);
    add_row(7'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, none);
    // longest length, keys unchanged
    add_row(7'd127, 8'h00, 8'h1E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, none);
    add_row(7'd8, 8'h55, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
            '{key: 8'h1E, is_press: 1'b0, modifier: 8'h00, flags: 4'h0, last: 1'b1});
    add_row(7'd8, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1,
            '{key: 8'hFF, is_press: 1'b1, modifier: 8'hFF, flags: 4'h0, last: 1'b1});
    add_row(7'd64, 8'hAA, 8'h1F, 8'h20, 8'h21, 8'h1E, 8'hFF, 8'h04, 1'b0, 1'b0, none);
    // repeated codes across slots
    add_row(7'd8, 8'h3C, 8'h1F, 8'h1F, 8'h1F, 8'h05, 8'h05, 8'h00, 1'b0, 1'b0, none);
    // reserved codes only
    add_row(7'd8, 8'hC3, 8'h01, 8'h02, 8'h03, 8'h00, 8'h03, 8'h01, 1'b0, 1'b0, none);
    add_row(7'd8, 8'h01, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 1'b0, 1'b0, none);
    // fully disjoint: a release and a press in every slot
    add_row(7'd8, 8'h80, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 1'b0, 1'b0, none);
    add_row(7'd9, 8'h22, 8'h0E, 8'h0F, 8'h10, 8'h11, 8'h12, 8'h13, 1'b0, 1'b0, none);
    add_row(7'd7, 8'h44, 8'h1E, 8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 1'b0, 1'b0, none);
    // codes around the softkey range
    add_row(7'd8, 8'h7F, 8'h22, 8'h1D, 8'h1E, 8'h21, 8'h20, 8'h1F, 1'b0, 1'b0, none);
    add_row(7'd8, 8'hFE, 8'h1D, 8'h22, 8'hFF, 8'hFE, 8'h04, 8'h00, 1'b0, 1'b0, none);
    add_row(7'd100, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 1'b0, none);
    add_row(7'd8, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, none);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (stim_tab[i]) send_report(stim_tab[i]);

    // Mostly well-formed reports that keep or shuffle held keys; some noise.
    long_reports = 0;
    while (long_reports < RANDOM_REPORTS) begin
      if (long_reports >= RANDOM_REPORTS - CALM_REPORTS) calm = 1'b1;
      r = '0;
      r.mod = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 10) r.len = 7'($urandom_range(0, 7));
      else if (pick < 80) r.len = MIN_REPORT_LEN;
      else r.len = 7'($urandom_range(8, 127));
      if ($urandom_range(0, 19) != 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 35) r.keys[i] = last_sent[i];
          else if (pick < 50) r.keys[i] = last_sent[$urandom_range(0, SLOTS - 1)];
          else if (pick < 70) r.keys[i] = SOFTKEY_FIRST + 8'($urandom_range(0, 3));
          else if (pick < 80) r.keys[i] = 8'($urandom_range(0, 3));
          else if (pick < 90) r.keys[i] = 8'h04 + 8'($urandom_range(0, 7));
          else r.keys[i] = 8'($urandom_range(0, 255));
        end
      end
      send_report(r);
      if (r.len >= MIN_REPORT_LEN) long_reports++;
    end
    s_axis_tvalid <= 1'b0;

    while (events_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/bkrd_pkg.sv
rtl/core/bkrd_front.sv
rtl/core/bkrd_queue.sv
rtl/core/bkrd_back.sv
rtl/core/boot_keyboard_report_differ.sv
rtl/core/bkrd_checker.sv
test/tb_boot_keyboard_report_differ.sv
